// File: rtl/klock_pkg.sv
// ----------------------------------------------------------------------------
// Code lock package
// Shared types, register map, key and event codes and reset values.
// ----------------------------------------------------------------------------
package klock_pkg;

  localparam int KLOCK_PIN_DIGITS = 4;
  localparam int KLOCK_ADDR_W     = 4;
  localparam int KLOCK_DATA_W     = 32;

  localparam logic [15:0] KLOCK_PIN_RST   = 16'h1234;
  localparam logic [31:0] KLOCK_CARD_RST  = 32'hDEAD_BEEF;
  localparam logic [3:0]  KLOCK_LIMIT_RST = 4'd3;
  localparam logic [7:0]  KLOCK_TICKS_RST = 8'd10;

  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  typedef enum logic [1:0] {
    REG_PIN_CODE      = 2'd0,
    REG_CARD_ID       = 2'd1,
    REG_ATTEMPT_LIMIT = 2'd2,
    REG_LOCKOUT_TICKS = 2'd3
  } klock_reg_e;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_CARD = 2'd1,
    OP_TICK = 2'd2
  } klock_op_e;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_STORED       = 4'd1,
    EV_CLEARED      = 4'd2,
    EV_PIN_OPEN     = 4'd3,
    EV_CARD_OPEN    = 4'd4,
    EV_BAD_PIN      = 4'd5,
    EV_BAD_CARD     = 4'd6,
    EV_LOCKOUT      = 4'd7,
    EV_RELOCKED     = 4'd8,
    EV_LOCKOUT_OVER = 4'd9
  } klock_event_e;

  typedef struct packed {
    logic [15:0] pin_code;
    logic [31:0] card_id;
    logic [3:0]  attempt_limit;
    logic [7:0]  lockout_ticks;
  } klock_cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  key_code;
    logic [31:0] card_uid;
  } klock_item_t;

  typedef struct packed {
    logic         unlocked;
    logic         locked_out;
    klock_event_e event_res;
    logic [3:0]   attempts;
    logic [2:0]   entry_length;
    logic [7:0]   ticks_left;
  } klock_res_t;

endpackage

// File: rtl/klock_if.sv
// ----------------------------------------------------------------------------
// Code lock channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface klock_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  key_code;
  logic [31:0] card_uid;

  modport source (output valid, output op, output key_code, output card_uid, input ready);
  modport sink   (input valid, input op, input key_code, input card_uid, output ready);
endinterface

interface klock_res_if;
  logic        valid;
  logic        ready;
  logic        unlocked;
  logic        locked_out;
  logic [3:0]  event_res;
  logic [3:0]  attempts;
  logic [2:0]  entry_length;
  logic [7:0]  ticks_left;

  modport source (output valid, output unlocked, output locked_out, output event_res,
                  output attempts, output entry_length, output ticks_left, input ready);
  modport sink   (input valid, input unlocked, input locked_out, input event_res,
                  input attempts, input entry_length, input ticks_left, output ready);
endinterface

// File: rtl/klock_regs.sv
// ----------------------------------------------------------------------------
// Code lock register file
// APB-style write/read port for PIN, card identifier, attempt limit, lockout.
// ----------------------------------------------------------------------------
module klock_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [klock_pkg::KLOCK_ADDR_W-1:0]  paddr,
  input  logic [klock_pkg::KLOCK_DATA_W-1:0]  pwdata,
  output logic [klock_pkg::KLOCK_DATA_W-1:0]  prdata,
  output logic                                pready,
  output klock_pkg::klock_cfg_t               cfg_o
);
  import klock_pkg::*;

  klock_cfg_t cfg_q;
  logic       wr_en;
  klock_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = klock_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_code      <= KLOCK_PIN_RST;
      cfg_q.card_id       <= KLOCK_CARD_RST;
      cfg_q.attempt_limit <= KLOCK_LIMIT_RST;
      cfg_q.lockout_ticks <= KLOCK_TICKS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PIN_CODE:      cfg_q.pin_code      <= pwdata[15:0];
        REG_CARD_ID:       cfg_q.card_id       <= pwdata[31:0];
        REG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= pwdata[3:0];
        REG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PIN_CODE:      prdata = {16'd0, cfg_q.pin_code};
      REG_CARD_ID:       prdata = cfg_q.card_id;
      REG_ATTEMPT_LIMIT: prdata = {28'd0, cfg_q.attempt_limit};
      REG_LOCKOUT_TICKS: prdata = {24'd0, cfg_q.lockout_ticks};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/klock_in_stage.sv
// ----------------------------------------------------------------------------
// Code lock input stage
// Register one input item; refill in the same cycle the held item advances.
// ----------------------------------------------------------------------------
module klock_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  klock_in_if.sink               item_i,
  input  logic                   advance_i,
  output logic                   valid_o,
  output klock_pkg::klock_item_t item_o
);
  import klock_pkg::*;

  logic        valid_q;
  klock_item_t item_q;
  logic        take;

  assign item_i.ready = !valid_q || advance_i;
  assign take         = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.op       <= item_i.op;
      item_q.key_code <= item_i.key_code;
      item_q.card_uid <= item_i.card_uid;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/klock_core.sv
// ----------------------------------------------------------------------------
// Code lock core
// Lock state, combinational step logic for one item and the result register.
// ----------------------------------------------------------------------------
module klock_core #(
  parameter int PIN_DIGITS = klock_pkg::KLOCK_PIN_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  klock_pkg::klock_cfg_t  cfg_i,
  input  logic                   valid_i,
  input  klock_pkg::klock_item_t item_i,
  output logic                   advance_o,
  klock_res_if.source            result_o
);
  import klock_pkg::*;

  localparam int EW   = 4 * PIN_DIGITS;
  localparam int CNTW = $clog2(PIN_DIGITS + 1);
  localparam int CW   = (EW > 16) ? EW : 16;
  localparam int LW   = (CNTW > 3) ? CNTW : 3;

  logic [EW-1:0]   keys_q, keys_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [3:0]      fail_q, fail_d;
  logic            open_q, open_d;
  logic            lock_q, lock_d;
  logic [7:0]      rem_q, rem_d;

  logic            res_valid_q;
  klock_res_t      res_q, res_d;

  logic [CW-1:0]   pin_wide;
  logic [EW-1:0]   pin_cmp;
  logic [3:0]      fail_inc;
  logic            limit_hit;
  logic [7:0]      rem_dec;
  logic            pin_match;
  logic [LW-1:0]   len_wide;
  logic            do_fail;
  klock_event_e    bad_ev;
  klock_event_e    ev;
  logic            advance;

  assign advance   = valid_i && (!res_valid_q || result_o.ready);
  assign advance_o = advance;

  assign pin_wide  = CW'(cfg_i.pin_code);
  assign pin_cmp   = pin_wide[EW-1:0];
  assign fail_inc  = fail_q + 4'd1;
  assign limit_hit = fail_inc >= cfg_i.attempt_limit;
  assign rem_dec   = (rem_q != 8'd0) ? rem_q - 8'd1 : 8'd0;
  assign pin_match = (count_q == CNTW'(PIN_DIGITS)) && (keys_q == pin_cmp);

  always_comb begin
    keys_d  = keys_q;
    count_d = count_q;
    fail_d  = fail_q;
    open_d  = open_q;
    lock_d  = lock_q;
    rem_d   = rem_q;
    ev      = EV_NONE;
    do_fail = 1'b0;
    bad_ev  = EV_BAD_PIN;
    case (item_i.op)
      OP_TICK: begin
        if (lock_q) begin
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            lock_d = 1'b0;
            ev     = EV_LOCKOUT_OVER;
          end
        end
      end
      OP_KEY: begin
        if (!lock_q) begin
          if (open_q) begin
            if (item_i.key_code == KEY_HASH) begin
              open_d = 1'b0;
              ev     = EV_RELOCKED;
            end
          end else if (item_i.key_code == KEY_HASH) begin
            keys_d  = '0;
            count_d = '0;
            if (pin_match) begin
              fail_d = 4'd0;
              open_d = 1'b1;
              ev     = EV_PIN_OPEN;
            end else begin
              do_fail = 1'b1;
              bad_ev  = EV_BAD_PIN;
            end
          end else if (item_i.key_code == KEY_STAR) begin
            keys_d  = '0;
            count_d = '0;
            ev      = EV_CLEARED;
          end else if (count_q < CNTW'(PIN_DIGITS)) begin
            keys_d  = (keys_q << 4) | EW'(item_i.key_code);
            count_d = count_q + 1'b1;
            ev      = EV_STORED;
          end
        end
      end
      OP_CARD: begin
        if (!lock_q && !open_q) begin
          if (item_i.card_uid == cfg_i.card_id) begin
            fail_d = 4'd0;
            open_d = 1'b1;
            ev     = EV_CARD_OPEN;
          end else begin
            do_fail = 1'b1;
            bad_ev  = EV_BAD_CARD;
          end
        end
      end
      default: ;
    endcase
    if (do_fail) begin
      if (limit_hit) begin
        fail_d = 4'd0;
        lock_d = 1'b1;
        rem_d  = cfg_i.lockout_ticks;
        ev     = EV_LOCKOUT;
      end else begin
        fail_d = fail_inc;
        ev     = bad_ev;
      end
    end
  end

  assign len_wide = LW'(count_d);

  always_comb begin
    res_d.unlocked     = open_d;
    res_d.locked_out   = lock_d;
    res_d.event_res    = ev;
    res_d.attempts     = fail_d;
    res_d.entry_length = len_wide[2:0];
    res_d.ticks_left   = rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q      <= '0;
      count_q     <= '0;
      fail_q      <= 4'd0;
      open_q      <= 1'b0;
      lock_q      <= 1'b0;
      rem_q       <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        keys_q  <= keys_d;
        count_q <= count_d;
        fail_q  <= fail_d;
        open_q  <= open_d;
        lock_q  <= lock_d;
        rem_q   <= rem_d;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.unlocked     = res_q.unlocked;
  assign result_o.locked_out   = res_q.locked_out;
  assign result_o.event_res    = res_q.event_res;
  assign result_o.attempts     = res_q.attempts;
  assign result_o.entry_length = res_q.entry_length;
  assign result_o.ticks_left   = res_q.ticks_left;

  a_open_excl_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(open_q && lock_q))
    else $error("lock open during lockout");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(PIN_DIGITS))
    else $error("entry count beyond PIN length");

  a_lockout_end_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(lock_q) |-> $past(advance && (item_i.op == OP_TICK)))
    else $error("lockout ended without a tick");

  a_lockout_clears_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lock_q) |-> (fail_q == 4'd0))
    else $error("failure count kept at lockout start");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("item advanced without a result");

endmodule

// File: rtl/keypad_rfid_code_lock_unit.sv
// ----------------------------------------------------------------------------
// Keypad and card code lock
// Takes key presses, card reads and one-second ticks; one result per item.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while the result side takes each result. Each
// item is held in the input register and is then resolved into the result
// register; the lock state, failure count and lockout timer are all updated by
// one combinational step block.
// Configuration writes take effect at the next item after the write.
module keypad_rfid_code_lock_unit #(
  parameter int PIN_DIGITS = klock_pkg::KLOCK_PIN_DIGITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [klock_pkg::KLOCK_ADDR_W-1:0]  paddr,
  input  logic [klock_pkg::KLOCK_DATA_W-1:0]  pwdata,
  output logic [klock_pkg::KLOCK_DATA_W-1:0]  prdata,
  output logic                                pready,
  klock_in_if.sink                            item_i,
  klock_res_if.source                         result_o
);
  import klock_pkg::*;

  klock_cfg_t  cfg;
  klock_item_t item_q;
  logic        item_valid;
  logic        advance;

  klock_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  klock_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item_q)
  );

  klock_core #(
    .PIN_DIGITS (PIN_DIGITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (item_valid),
    .item_i    (item_q),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Code lock testbench
// Drives key presses, card reads and ticks into the lock through its item
// channel and sets its registers over the APB port between phases. A status
// board predicts the lock status after every accepted item and checks each
// result in order. Both channels idle at random, and the result side holds
// off for a long stretch once so that the input side stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import klock_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned IDLE_PCT      = 9;
  localparam int unsigned STALL_CYCLES  = 200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  class lock_status_board;
    logic [15:0]  pin_code;
    logic [31:0]  card_id;
    logic [3:0]   attempt_limit;
    logic [7:0]   lockout_ticks;
    logic [15:0]  entry_keys;
    logic [2:0]   entry_count;
    logic [3:0]   fail_count;
    logic         open_flag;
    logic         lockout_flag;
    logic [7:0]   lockout_left;
    klock_res_t   status_due[$];
    int unsigned  mismatches;

    function new();
      pin_code      = KLOCK_PIN_RST;
      card_id       = KLOCK_CARD_RST;
      attempt_limit = KLOCK_LIMIT_RST;
      lockout_ticks = KLOCK_TICKS_RST;
      entry_keys    = '0;
      entry_count   = '0;
      fail_count    = '0;
      open_flag     = 1'b0;
      lockout_flag  = 1'b0;
      lockout_left  = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(klock_reg_e r, logic [31:0] value);
      case (r)
        REG_PIN_CODE:      pin_code      = value[15:0];
        REG_CARD_ID:       card_id       = value;
        REG_ATTEMPT_LIMIT: attempt_limit = value[3:0];
        REG_LOCKOUT_TICKS: lockout_ticks = value[7:0];
        default: ;
      endcase
    endfunction

    function klock_event_e count_failure(klock_event_e bad);
      fail_count = fail_count + 4'd1;
      if (fail_count >= attempt_limit) begin
        fail_count   = '0;
        lockout_flag = 1'b1;
        lockout_left = lockout_ticks;
        return EV_LOCKOUT;
      end
      return bad;
    endfunction

    function klock_event_e press_key(logic [3:0] key);
      logic hit;
      if (open_flag) begin
        if (key == KEY_HASH) begin
          open_flag = 1'b0;
          return EV_RELOCKED;
        end
        return EV_NONE;
      end
      if (key == KEY_HASH) begin
        hit = (entry_count == KLOCK_PIN_DIGITS) && (entry_keys == pin_code);
        entry_keys  = '0;
        entry_count = '0;
        if (hit) begin
          fail_count = '0;
          open_flag  = 1'b1;
          return EV_PIN_OPEN;
        end
        return count_failure(EV_BAD_PIN);
      end
      if (key == KEY_STAR) begin
        entry_keys  = '0;
        entry_count = '0;
        return EV_CLEARED;
      end
      if (entry_count < KLOCK_PIN_DIGITS) begin
        entry_keys  = {entry_keys[11:0], key};
        entry_count = entry_count + 3'd1;
        return EV_STORED;
      end
      return EV_NONE;
    endfunction

    function klock_event_e read_card(logic [31:0] uid);
      if (open_flag)
        return EV_NONE;
      if (uid == card_id) begin
        fail_count = '0;
        open_flag  = 1'b1;
        return EV_CARD_OPEN;
      end
      return count_failure(EV_BAD_CARD);
    endfunction

    function void take_item(klock_item_t it);
      klock_event_e ev;
      klock_res_t   st;
      ev = EV_NONE;
      if (it.op == OP_TICK) begin
        if (lockout_flag) begin
          if (lockout_left != 0)
            lockout_left = lockout_left - 8'd1;
          if (lockout_left == 0) begin
            lockout_flag = 1'b0;
            ev = EV_LOCKOUT_OVER;
          end
        end
      end else if (!lockout_flag && it.op == OP_KEY) begin
        ev = press_key(it.key_code);
      end else if (!lockout_flag && it.op == OP_CARD) begin
        ev = read_card(it.card_uid);
      end
      st.unlocked     = open_flag;
      st.locked_out   = lockout_flag;
      st.event_res    = ev;
      st.attempts     = fail_count;
      st.entry_length = entry_count;
      st.ticks_left   = lockout_left;
      status_due.push_back(st);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
      mismatches++;
    endfunction

    function void check_status(klock_res_t seen);
      klock_res_t want;
      if (status_due.size() == 0) begin
        $display("%0t: result with none expected, got %p", $time, seen);
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      if (seen.unlocked !== want.unlocked)
        report("unlocked", want.unlocked, seen.unlocked);
      if (seen.locked_out !== want.locked_out)
        report("locked_out", want.locked_out, seen.locked_out);
      if (seen.event_res !== want.event_res)
        report("event_res", want.event_res, seen.event_res);
      if (seen.attempts !== want.attempts)
        report("attempts", want.attempts, seen.attempts);
      if (seen.entry_length !== want.entry_length)
        report("entry_length", want.entry_length, seen.entry_length);
      if (seen.ticks_left !== want.ticks_left)
        report("ticks_left", want.ticks_left, seen.ticks_left);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [KLOCK_ADDR_W-1:0] paddr;
  logic [KLOCK_DATA_W-1:0] pwdata;
  logic [KLOCK_DATA_W-1:0] prdata;
  logic                    pready;

  klock_in_if  item_if();
  klock_res_if result_if();

  lock_status_board board;
  bit               calm;
  bit               stall_request;
  int unsigned      cycles;

  keypad_rfid_code_lock_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_if),
    .result_o (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left    = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : watch_channels
    klock_item_t it;
    klock_res_t  seen;
    if (rst_ni && item_if.valid && item_if.ready) begin
      it.op       = item_if.op;
      it.key_code = item_if.key_code;
      it.card_uid = item_if.card_uid;
      board.take_item(it);
    end
    if (rst_ni && result_if.valid && result_if.ready) begin
      seen.unlocked     = result_if.unlocked;
      seen.locked_out   = result_if.locked_out;
      seen.event_res    = klock_event_e'(result_if.event_res);
      seen.attempts     = result_if.attempts;
      seen.entry_length = result_if.entry_length;
      seen.ticks_left   = result_if.ticks_left;
      board.check_status(seen);
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] key, logic [31:0] uid);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.op       <= op;
    item_if.key_code <= key;
    item_if.card_uid <= uid;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  task automatic write_reg(klock_reg_e r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(r, value);
    @(posedge clk_i);
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_lock(logic [15:0] pin, logic [31:0] card, logic [3:0] limit,
                          logic [7:0] ticks);
    write_reg(REG_PIN_CODE, {16'h0, pin});
    write_reg(REG_CARD_ID, card);
    write_reg(REG_ATTEMPT_LIMIT, {28'h0, limit});
    write_reg(REG_LOCKOUT_TICKS, {24'h0, ticks});
  endtask

  function automatic logic [15:0] enterable_pin();
    return {4'($urandom_range(13)), 4'($urandom_range(13)),
            4'($urandom_range(13)), 4'($urandom_range(13))};
  endfunction

  task automatic run_phase(int unsigned count);
    int unsigned done_items;
    int unsigned pick;
    int unsigned len;
    int unsigned burst;
    bit          good;
    logic [3:0]  key;
    logic [31:0] uid;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(99);
      if (board.lockout_flag && pick < 80) begin
        send_item(OP_TICK, 4'($urandom), $urandom);
        done_items++;
      end else if (board.open_flag && pick < 40) begin
        send_item(OP_KEY, KEY_HASH, $urandom);
        done_items++;
      end else if (pick < 45) begin
        len  = ($urandom_range(3) == 0) ? $urandom_range(5) : 4;
        good = $urandom_range(1);
        for (int k = 0; k < len; k++) begin
          key = (good && k < 4) ? board.pin_code[15-4*k -: 4] : 4'($urandom_range(13));
          send_item(OP_KEY, key, $urandom);
        end
        send_item(OP_KEY, KEY_HASH, $urandom);
        done_items += len + 1;
      end else if (pick < 65) begin
        pick = $urandom_range(9);
        if (pick < 5)
          uid = board.card_id;
        else if (pick < 7)
          uid = board.card_id ^ (32'h1 << $urandom_range(31));
        else
          uid = $urandom;
        send_item(OP_CARD, 4'($urandom), uid);
        done_items++;
      end else if (pick < 75) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_item(OP_TICK, 4'($urandom), $urandom);
        done_items += burst;
      end else if (pick < 82) begin
        send_item(OP_KEY, KEY_STAR, $urandom);
        done_items++;
      end else if (pick < 88) begin
        send_item(OP_KEY, KEY_HASH, $urandom);
        done_items++;
      end else begin
        send_item(2'($urandom_range(3)), 4'($urandom), $urandom);
        done_items++;
      end
    end
  endtask

  initial begin : stimulus
    board         = new();
    calm          = 1'b0;
    stall_request = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    item_if.valid    = 1'b0;
    item_if.op       = OP_KEY;
    item_if.key_code = '0;
    item_if.card_uid = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_UNUSED, 4'd3, 32'h0);
    send_item(OP_TICK, 4'd0, 32'h0);
    send_item(OP_KEY, 4'd7, 32'h0);
    send_item(OP_CARD, 4'd0, KLOCK_CARD_RST);
    send_item(OP_CARD, 4'd0, 32'h0);
    send_item(OP_KEY, 4'd9, 32'h0);
    send_item(OP_KEY, KEY_HASH, 32'h0);
    send_item(OP_KEY, KEY_STAR, 32'h0);
    for (int k = 0; k < 4; k++)
      send_item(OP_KEY, KLOCK_PIN_RST[15-4*k -: 4], 32'h0);
    send_item(OP_KEY, 4'd13, 32'h0);
    send_item(OP_KEY, KEY_HASH, 32'h0);
    send_item(OP_KEY, KEY_HASH, 32'h0);
    send_item(OP_KEY, 4'd0, 32'h0);
    send_item(OP_KEY, KEY_HASH, 32'h0);
    send_item(OP_CARD, 4'd0, 32'h0);
    send_item(OP_CARD, 4'd0, 32'hFFFF_FFFF);
    send_item(OP_KEY, 4'd5, 32'h0);
    send_item(OP_CARD, 4'd0, KLOCK_CARD_RST);
    repeat (KLOCK_TICKS_RST) send_item(OP_TICK, 4'd0, 32'h0);
    run_phase(150);
    settle();

    // no idling on either side through this phase
    set_lock(16'h0000, 32'h0000_0000, 4'd1, 8'd1);
    calm = 1'b1;
    run_phase(150);
    settle();
    calm = 1'b0;

    set_lock(16'hFFFF, 32'hFFFF_FFFF, 4'd15, 8'd255);
    run_phase(150);
    settle();
    set_lock(16'hDDDD, 32'hFFFF_FFFF, 4'd15, 8'd255);
    run_phase(150);
    settle();

    // hold off results while items keep coming
    set_lock(enterable_pin(), $urandom, 4'd0, 8'd0);
    stall_request = 1'b1;
    run_phase(150);
    settle();

    set_lock(enterable_pin(), $urandom, 4'($urandom_range(1, 15)), 8'($urandom_range(1, 20)));
    run_phase(150);
    settle();
    set_lock(enterable_pin(), $urandom, 4'($urandom_range(1, 4)), 8'($urandom_range(1, 6)));
    run_phase(120);
    settle();

    if (board.mismatches == 0 && board.status_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
